// ----- rtl/kfd_pkg.sv -----
package kfd_pkg;

   // Default sizes of the typed-key FIFO and of the pressed map.
   localparam int FIFO_DEPTH_DEF = 16;
   localparam int KEY_CODES_DEF  = 256;

   // Request operation codes.
   localparam logic [2:0] OP_CLEAR       = 3'd0;
   localparam logic [2:0] OP_NEXT_KEY    = 3'd1;
   localparam logic [2:0] OP_KEY_QUERY   = 3'd2;
   localparam logic [2:0] OP_SET_MESSAGE = 3'd3;
   localparam logic [2:0] OP_KEY_TYPED   = 3'd4;
   localparam logic [2:0] OP_KEY_UPDATE  = 3'd5;
   localparam logic [2:0] OP_RAISE       = 3'd6;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] word;
      logic        pressed;
   } kfd_req_type;

   typedef struct packed {
      logic [15:0] read_value;
      logic        read_valid;
      logic        irq_request;
      logic [15:0] irq_message;
   } kfd_rsp_type;

endpackage

// ----- rtl/keyboard_fifo_device_unit.sv -----
// Channel    Ports                          Direction  Handshake
// request    start, busy, req_item          in         taken when start is high and busy is low
// response   rsp_strobe, rsp_item           out        shown for one cycle, always taken
//
// Every request goes as follows: the accepting edge reads the FIFO entry at the read
// pointer and the pressed-map bit at the request's key index into registers, and the next
// edge registers the response, which is on the ports for the cycle after, and writes the
// FIFO or the map. The registered reads of the memories and this read-then-write
// turn set this order; busy stays high while the request is in ST_EXEC, so a new
// request is not taken before the last one is through.
// After reset the pressed map is swept to zero, one bit a cycle, with busy high
// throughout. The receiver cannot stall, so no response is ever held back.
module keyboard_fifo_device_unit
   import kfd_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
   parameter int KEY_CODES  = KEY_CODES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  kfd_req_type req_item,
   output logic        rsp_strobe,
   output kfd_rsp_type rsp_item
);

   // Pointer widths; a FIFO of one entry still gets a one-bit pointer.
   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int KEY_W = $clog2(KEY_CODES);

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
   localparam logic [KEY_W-1:0] KEY_LAST = KEY_W'(KEY_CODES - 1);
   localparam logic [16:0]      KEY_LIMIT = 17'(KEY_CODES);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type         state_ff;
   kfd_req_type       item_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [15:0]       message_ff;
   logic [KEY_W-1:0]  clr_ptr_ff;
   logic              rsp_strobe_ff;
   kfd_rsp_type       rsp_ff;

   // The two memories and their registered read data.
   logic [15:0]       fifo_mem [FIFO_DEPTH];
   logic              map_mem [KEY_CODES];
   logic [15:0]       fifo_rd_ff;
   logic              map_rd_ff;

   logic              accept;
   logic              item_in_map;
   logic              fifo_wr_en;
   logic              map_wr_en;
   logic [KEY_W-1:0]  map_wr_addr;
   logic              map_wr_data;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [CNT_W-1:0]  count_in;
   logic [15:0]       message_in;
   kfd_rsp_type       rsp_in;

   assign accept      = start && (state_ff == ST_IDLE);
   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_item    = rsp_ff;
   assign item_in_map = ({1'b0, item_ff.word} < KEY_LIMIT);

   // Execute state of a request: the read data are in, work out the response and the
   // state updates. The sweep after reset shares the map's write port.
   always_comb begin
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      count_in    = count_ff;
      message_in  = message_ff;
      rsp_in      = '0;
      fifo_wr_en  = 1'b0;
      map_wr_en   = 1'b0;
      map_wr_addr = item_ff.word[KEY_W-1:0];
      map_wr_data = item_ff.pressed;
      if (state_ff == ST_CLEAR) begin
         map_wr_en   = 1'b1;
         map_wr_addr = clr_ptr_ff;
         map_wr_data = 1'b0;
      end else if (state_ff == ST_EXEC) begin
         case (item_ff.operation)
            OP_CLEAR: begin
               rd_ptr_in = '0;
               wr_ptr_in = '0;
               count_in  = '0;
            end
            OP_NEXT_KEY: begin
               rsp_in.read_valid = 1'b1;
               if (count_ff != '0) begin
                  rsp_in.read_value = fifo_rd_ff;
                  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
                  count_in  = count_ff - 1'b1;
               end
            end
            OP_KEY_QUERY: begin
               rsp_in.read_valid = 1'b1;
               if (item_in_map) begin
                  rsp_in.read_value = {15'd0, map_rd_ff};
               end
            end
            OP_SET_MESSAGE: begin
               message_in = item_ff.word;
            end
            OP_KEY_TYPED: begin
               if (count_ff < CNT_FULL) begin
                  fifo_wr_en = 1'b1;
                  wr_ptr_in  = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
                  count_in   = count_ff + 1'b1;
               end
            end
            OP_KEY_UPDATE: begin
               map_wr_en = item_in_map;
            end
            OP_RAISE: begin
               if (message_ff != '0) begin
                  rsp_in.irq_request = 1'b1;
                  rsp_in.irq_message = message_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         count_ff      <= '0;
         message_ff    <= '0;
         clr_ptr_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ptr_ff <= clr_ptr_ff + 1'b1;
               if (clr_ptr_ff == KEY_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               rd_ptr_ff     <= rd_ptr_in;
               wr_ptr_ff     <= wr_ptr_in;
               count_ff      <= count_in;
               message_ff    <= message_in;
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Payload registers: the request held for its execute state and the response.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
      rsp_ff <= rsp_in;
   end

   // Memory ports. Reads run every cycle; the data that matter are those captured at the
   // edge that accepts a request, from the request's own key index and the read pointer.
   always_ff @(posedge clock) begin
      fifo_rd_ff <= fifo_mem[rd_ptr_ff];
      map_rd_ff  <= map_mem[req_item.word[KEY_W-1:0]];
      if (fifo_wr_en) begin
         fifo_mem[wr_ptr_ff] <= item_ff.word;
      end
      if (map_wr_en) begin
         map_mem[map_wr_addr] <= map_wr_data;
      end
   end

endmodule

// ----- sim/keyboard_fifo_device_unit_test.sv -----
`timescale 1ns / 100ps

module keyboard_fifo_device_unit_test;
   import kfd_pkg::*;

   // The one operation code the package leaves unnamed; the block must ignore it.
   localparam logic [2:0] OP_UNUSED = 3'd7;

   // Number of useful requests in the random part, and the point after which the
   // sender stops pausing so the run ends at full rate.
   localparam int RANDOM_ITEMS = 1850;
   localparam int QUIET_FROM   = 1600;
   // Slowest correct run: every request with its handshake and the idle pause before it,
   // plus the pressed-map sweep after reset. The limit is many times that.
   localparam int CYCLE_LIMIT  = 200000;

   // Keeps its own copy of the FIFO, the pressed map and the message register,
   // works out the response to each accepted request and checks the block's
   // responses against them in order.
   class key_tracker;
      logic [15:0]  key_store[FIFO_DEPTH_DEF];
      int unsigned  key_count;
      int unsigned  read_ptr;
      bit           key_down[KEY_CODES_DEF];
      logic [15:0]  message = '0;
      kfd_rsp_type  expected_rsps[$];
      int           errors;

      function kfd_rsp_type predict_response(kfd_req_type req);
         kfd_rsp_type rsp;
         rsp = '0;
         case (req.operation)
            OP_CLEAR: begin
               key_count = 0;
               read_ptr  = 0;
            end
            OP_NEXT_KEY: begin
               rsp.read_valid = 1'b1;
               if (key_count > 0) begin
                  rsp.read_value = key_store[read_ptr];
                  read_ptr       = (read_ptr + 1) % FIFO_DEPTH_DEF;
                  key_count--;
               end
            end
            OP_KEY_QUERY: begin
               rsp.read_valid = 1'b1;
               if (req.word < KEY_CODES_DEF)
                  rsp.read_value = {15'd0, key_down[req.word]};
            end
            OP_SET_MESSAGE: message = req.word;
            OP_KEY_TYPED: begin
               if (key_count < FIFO_DEPTH_DEF) begin
                  key_store[(read_ptr + key_count) % FIFO_DEPTH_DEF] = req.word;
                  key_count++;
               end
            end
            OP_KEY_UPDATE: begin
               if (req.word < KEY_CODES_DEF)
                  key_down[req.word] = req.pressed;
            end
            OP_RAISE: begin
               if (message != 16'd0) begin
                  rsp.irq_request = 1'b1;
                  rsp.irq_message = message;
               end
            end
            default: ;
         endcase
         return rsp;
      endfunction

      function void note_request(kfd_req_type req);
         expected_rsps.push_back(predict_response(req));
      endfunction

      function void check_response(kfd_rsp_type rsp);
         kfd_rsp_type exp_rsp;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h, none was expected", $time, rsp);
            errors++;
            return;
         end
         exp_rsp = expected_rsps.pop_front();
         if (rsp.read_value !== exp_rsp.read_value) begin
            $display("%0t: read_value expected %h got %h", $time,
                     exp_rsp.read_value, rsp.read_value);
            errors++;
         end
         if (rsp.read_valid !== exp_rsp.read_valid) begin
            $display("%0t: read_valid expected %b got %b", $time,
                     exp_rsp.read_valid, rsp.read_valid);
            errors++;
         end
         if (rsp.irq_request !== exp_rsp.irq_request) begin
            $display("%0t: irq_request expected %b got %b", $time,
                     exp_rsp.irq_request, rsp.irq_request);
            errors++;
         end
         if (rsp.irq_message !== exp_rsp.irq_message) begin
            $display("%0t: irq_message expected %h got %h", $time,
                     exp_rsp.irq_message, rsp.irq_message);
            errors++;
         end
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   kfd_req_type req_item = '0;
   logic        rsp_strobe;
   kfd_rsp_type rsp_item;

   key_tracker  tracker;
   int          cycle_count = 0;
   int          useful_items = 0;
   bit          idle_on = 1'b0;

   keyboard_fifo_device_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #5 clock = ~clock;

   // Watchdog. If the block stops answering or stays busy for good, the run is
   // stopped here rather than hanging.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Monitor. Both handshakes are judged on the values present just before the
   // rising edge. A response seen at an edge always belongs to a request accepted
   // at an earlier edge, so it is checked before a request taken at the same edge
   // is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1)
            tracker.check_response(rsp_item);
         if (start && busy === 1'b0)
            tracker.note_request(req_item);
      end
   end

   // Presents one request at a falling edge and holds it until the block takes it.
   // When pausing is enabled, a random pause with start low may come first.
   // Start is left high after acceptance; busy keeps the block from taking the
   // same request twice, and the next call either changes the payload or lowers
   // start, so start only ever receives one assignment per falling edge.
   task automatic send_request(input logic [2:0] op, input logic [15:0] word,
                               input logic prs);
      kfd_req_type req;
      req.operation = op;
      req.word      = word;
      req.pressed   = prs;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 2)) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_item <= req;
      do @(posedge clock); while (busy !== 1'b0);
      // Requests with the unused operation code and key updates outside the map are not counted as useful work.
      if (op != OP_UNUSED && !(op == OP_KEY_UPDATE && word >= KEY_CODES_DEF))
         useful_items++;
   endtask

   // Holds the sender off until every response already owed has come back.
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // Random 16-bit value, weighted toward the two extremes.
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   // Key index: mostly inside the map, with the map edge and far-out indexes mixed in.
   function automatic logic [15:0] pick_key();
      case ($urandom_range(0, 9))
         0:       return 16'(KEY_CODES_DEF - 1);
         1:       return 16'(KEY_CODES_DEF);
         2:       return 16'($urandom());
         default: return 16'($urandom_range(0, KEY_CODES_DEF - 1));
      endcase
   endfunction

   initial begin
      logic [15:0] key;
      int          n;
      bit          drained_once;
      tracker      = new();
      drained_once = 1'b0;

      // Synchronous reset, released on a falling edge. The block
      // then sweeps its pressed map with busy high; the first request simply waits.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty FIFO, map edges, out-of-map queries and updates,
      // raise with and without a message, extreme key codes, clear, and the
      // unused operation code.
      send_request(OP_NEXT_KEY,    16'h0000, 1'b0);
      send_request(OP_KEY_QUERY,   16'h0000, 1'b0);
      send_request(OP_KEY_UPDATE,  16'h0000, 1'b1);
      send_request(OP_KEY_UPDATE,  16'(KEY_CODES_DEF - 1), 1'b1);
      send_request(OP_KEY_UPDATE,  16'(KEY_CODES_DEF), 1'b1);
      send_request(OP_KEY_UPDATE,  16'hFFFF, 1'b1);
      send_request(OP_KEY_QUERY,   16'h0000, 1'b0);
      send_request(OP_KEY_QUERY,   16'(KEY_CODES_DEF - 1), 1'b0);
      send_request(OP_KEY_QUERY,   16'(KEY_CODES_DEF), 1'b0);
      send_request(OP_KEY_QUERY,   16'hFFFF, 1'b1);
      send_request(OP_KEY_UPDATE,  16'h0000, 1'b0);
      send_request(OP_KEY_QUERY,   16'h0000, 1'b0);
      send_request(OP_RAISE,       16'hFFFF, 1'b1);
      send_request(OP_SET_MESSAGE, 16'hFFFF, 1'b0);
      send_request(OP_RAISE,       16'h0000, 1'b0);
      send_request(OP_SET_MESSAGE, 16'h0001, 1'b0);
      send_request(OP_RAISE,       16'h0000, 1'b0);
      send_request(OP_KEY_TYPED,   16'hFFFF, 1'b0);
      send_request(OP_KEY_TYPED,   16'h0000, 1'b1);
      send_request(OP_KEY_TYPED,   16'h5555, 1'b1);
      send_request(OP_NEXT_KEY,    16'hAAAA, 1'b1);
      send_request(OP_CLEAR,       16'hFFFF, 1'b1);
      send_request(OP_NEXT_KEY,    16'h0000, 1'b0);
      send_request(OP_UNUSED,      16'hFFFF, 1'b1);
      send_request(OP_SET_MESSAGE, 16'h0000, 1'b0);

      // Let everything owed so far come back before the random part starts.
      wait_drained();
      useful_items = 0;

      // Random part: mostly coherent sequences (typing bursts that fill and
      // overflow the FIFO, pop bursts that drain it past empty, press/release
      // followed by a query of the same key, message then raise), plus clears
      // and raw noise. Pausing is switched on and off per sequence so there
      // are stretches with and without gaps, and is off for the last stretch.
      while (useful_items < RANDOM_ITEMS) begin
         idle_on = (useful_items < QUIET_FROM) && ($urandom_range(0, 2) != 0);

         // Once, midway, hold the sender until the block has answered everything.
         if (!drained_once && useful_items >= RANDOM_ITEMS / 2) begin
            wait_drained();
            drained_once = 1'b1;
         end

         case ($urandom_range(0, 9))
            0, 1: begin
               n = $urandom_range(1, 20);
               repeat (n) send_request(OP_KEY_TYPED, pick_word(), 1'($urandom()));
            end
            2, 3: begin
               n = $urandom_range(1, 20);
               repeat (n) send_request(OP_NEXT_KEY, pick_word(), 1'($urandom()));
            end
            4: begin
               // Fill to the brim and push a few more, which must be dropped.
               n = FIFO_DEPTH_DEF + $urandom_range(1, 3);
               repeat (n) send_request(OP_KEY_TYPED, pick_word(), 1'($urandom()));
               n = $urandom_range(1, FIFO_DEPTH_DEF + 2);
               repeat (n) send_request(OP_NEXT_KEY, pick_word(), 1'($urandom()));
            end
            5, 6: begin
               n = $urandom_range(1, 6);
               repeat (n) begin
                  key = pick_key();
                  send_request(OP_KEY_UPDATE, key, 1'($urandom()));
                  if ($urandom_range(0, 2) != 0)
                     send_request(OP_KEY_QUERY, key, 1'($urandom()));
                  else
                     send_request(OP_KEY_QUERY, pick_key(), 1'($urandom()));
               end
            end
            7: begin
               if ($urandom_range(0, 3) == 0)
                  send_request(OP_SET_MESSAGE, 16'h0000, 1'($urandom()));
               else
                  send_request(OP_SET_MESSAGE, pick_word(), 1'($urandom()));
               repeat ($urandom_range(1, 2))
                  send_request(OP_RAISE, pick_word(), 1'($urandom()));
            end
            8: begin
               repeat ($urandom_range(0, 4))
                  send_request(OP_KEY_TYPED, pick_word(), 1'($urandom()));
               send_request(OP_CLEAR, pick_word(), 1'($urandom()));
            end
            default: begin
               // Noise: any operation code, any payload.
               repeat ($urandom_range(1, 4))
                  send_request(3'($urandom_range(0, 7)), pick_word(), 1'($urandom()));
            end
         endcase
      end

      // All requests are in. Wait for the last responses, then keep watching the block
      // in case it sends something nobody asked for.
      wait_drained();
      repeat (10) @(posedge clock);

      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/kfd_pkg.sv
rtl/keyboard_fifo_device_unit.sv
sim/keyboard_fifo_device_unit_test.sv
